FILE: src/tbd_pkg.sv
package tbd_pkg;

	typedef logic signed [31:0] q_t;

	typedef struct packed {
		q_t vx;
		q_t vy;
		q_t r;
		q_t drive;
		q_t fx1;
		q_t fdrag;
	} side_t;

	typedef struct packed {
		q_t sy;
		q_t cy;
		q_t ss;
		q_t cs;
	} trig_t;

	localparam int CORDIC_STEPS = 17;
	localparam int AT_LAT = CORDIC_STEPS + 1;
	localparam int SC_LAT = CORDIC_STEPS + 4;

	localparam logic [15:0] ATAN_TAB [CORDIC_STEPS] = '{
		16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
		16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2, 16'd1
	};

	localparam logic [18:0] TWO_PI_Q = 19'd411775;
	localparam logic [18:0] PI_Q = 19'd205887;
	localparam logic [18:0] HALF_PI_Q = 19'd102944;
	localparam logic [18:0] MOD_OFFSET = 19'd77023;
	localparam logic [29:0] CORDIC_GAIN = 30'd652032874;
	localparam logic [31:0] ONE_Q = 32'd65536;

	localparam logic [2:0] REG_MOTOR_GAIN = 3'd0;
	localparam logic [2:0] REG_SPEED_LOSS = 3'd1;
	localparam logic [2:0] REG_DRAG = 3'd2;
	localparam logic [2:0] REG_ROLL = 3'd3;
	localparam logic [2:0] REG_FRONT_BCD = 3'd4;
	localparam logic [2:0] REG_REAR_BCD = 3'd5;
	localparam logic [2:0] REG_AXLES = 3'd6;
	localparam logic [2:0] REG_INV_MI = 3'd7;

	function automatic q_t sat_q(input logic signed [48:0] v);
		q_t res;
		if (v > 49'sd2147483647) begin
			res = 32'sh7fffffff;
		end else if (v < -49'sd2147483648) begin
			res = 32'sh80000000;
		end else begin
			res = v[31:0];
		end
		return res;
	endfunction

	function automatic q_t add_q(input q_t a, input q_t b);
		logic signed [48:0] s;
		s = 49'(a) + 49'(b);
		return sat_q(s);
	endfunction

	function automatic q_t sub_q(input q_t a, input q_t b);
		logic signed [48:0] s;
		s = 49'(a) - 49'(b);
		return sat_q(s);
	endfunction

	// saturated -(a + b)
	function automatic q_t nsum_q(input q_t a, input q_t b);
		logic signed [48:0] s;
		s = -(49'(a) + 49'(b));
		return sat_q(s);
	endfunction

	// full product, floor shift by 16, saturate
	function automatic q_t mulq(input logic signed [32:0] a, input q_t b);
		logic signed [64:0] p;
		p = 65'(a) * 65'(b);
		return sat_q(p[64:16]);
	endfunction

	function automatic logic signed [32:0] ext33(input q_t v);
		return $signed({v[31], v});
	endfunction

	function automatic logic signed [32:0] tire33(input logic [15:0] f);
		return $signed({9'b0, f, 8'b0});
	endfunction

	function automatic logic signed [32:0] axle33(input logic [23:0] f);
		return $signed({9'b0, f});
	endfunction

	function automatic logic signed [32:0] inv33(input logic [23:0] f);
		return $signed({5'b0, f, 4'b0});
	endfunction

endpackage

FILE: src/tbd_delay.sv
module tbd_delay #(
	parameter int W = 32,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] tap_s [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				tap_s[k] <= tap_s[k-1];
			end
		end
	end

	assign q = tap_s[DEPTH-1];

endmodule

FILE: src/tbd_atan2.sv
module tbd_atan2 (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] yv,
	input  logic signed [31:0] xv,
	output logic signed [31:0] angle
);

	localparam int N = tbd_pkg::CORDIC_STEPS;
	localparam logic signed [20:0] PI21 = $signed({2'b0, tbd_pkg::PI_Q});

	logic signed [51:0] x_s [N+1];
	logic signed [51:0] y_s [N+1];
	logic signed [20:0] z_s [N+1];
	logic               zf_s [N+1];

	logic signed [51:0] x0, y0;
	logic signed [20:0] z0;

	always_comb begin
		x0 = $signed({{4{xv[31]}}, xv, 16'b0});
		y0 = $signed({{4{yv[31]}}, yv, 16'b0});
		z0 = '0;
		if (xv < 0) begin
			x0 = -x0;
			y0 = -y0;
			z0 = (yv >= 0) ? PI21 : -PI21;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= x0;
			y_s[0] <= y0;
			z_s[0] <= z0;
			zf_s[0] <= (xv == 0) && (yv == 0);
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [20:0] AZ = $signed({5'b0, tbd_pkg::ATAN_TAB[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AZ;
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AZ;
				end
				zf_s[i+1] <= zf_s[i];
			end
		end
	end

	assign angle = zf_s[N] ? '0 : 32'(z_s[N]);

endmodule

FILE: src/tbd_sincos.sv
module tbd_sincos (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] angle,
	output logic signed [31:0] sin_val,
	output logic signed [31:0] cos_val
);

	localparam int N = tbd_pkg::CORDIC_STEPS;
	localparam int RSH = 50;
	localparam logic [63:0] RECIP_W = (64'd1 << RSH) / 64'(tbd_pkg::TWO_PI_Q);
	localparam logic [31:0] RECIP = RECIP_W[31:0];
	localparam logic [32:0] P33 = 33'(tbd_pkg::TWO_PI_Q);
	localparam logic signed [20:0] P21 = $signed({2'b0, tbd_pkg::TWO_PI_Q});
	localparam logic signed [20:0] PI21 = $signed({2'b0, tbd_pkg::PI_Q});
	localparam logic signed [20:0] HP21 = $signed({2'b0, tbd_pkg::HALF_PI_Q});
	localparam logic signed [20:0] OFF21 = $signed({2'b0, tbd_pkg::MOD_OFFSET});

	logic [31:0] u_s1;
	logic [63:0] prod_s1;
	logic [32:0] rem_s2;

	logic signed [33:0] x_s [N+1];
	logic signed [33:0] y_s [N+1];
	logic signed [19:0] z_s [N+1];
	logic               neg_s [N+1];

	logic [31:0]        ub;
	logic [13:0]        quo;
	logic [32:0]        qp;
	logic [32:0]        rem_c;
	logic signed [20:0] r_m, r_a, r_w, r_f;
	logic               neg_c;
	logic signed [33:0] xsh, ysh;

	// offset binary keeps the modulo unsigned; offset is 2^31 mod 2*pi
	assign ub = angle ^ 32'h8000_0000;

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1 <= ub;
			prod_s1 <= 64'(ub) * 64'(RECIP);
		end
	end

	assign quo = prod_s1[63:RSH];
	assign qp = 33'(quo) * P33;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s2 <= {1'b0, u_s1} - qp;
		end
	end

	always_comb begin
		rem_c = (rem_s2 >= P33) ? rem_s2 - P33 : rem_s2;
		r_m = $signed({2'b0, rem_c[18:0]}) - OFF21;
		r_a = (r_m < 0) ? r_m + P21 : r_m;
		r_w = (r_a > PI21) ? r_a - P21 : r_a;
		neg_c = 1'b0;
		r_f = r_w;
		if (r_w > HP21) begin
			r_f = r_w - PI21;
			neg_c = 1'b1;
		end else if (r_w < -HP21) begin
			r_f = r_w + PI21;
			neg_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= $signed({4'b0, tbd_pkg::CORDIC_GAIN});
			y_s[0] <= '0;
			z_s[0] <= r_f[19:0];
			neg_s[0] <= neg_c;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		localparam logic signed [19:0] AZ = $signed({4'b0, tbd_pkg::ATAN_TAB[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - AZ;
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + AZ;
				end
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	assign xsh = x_s[N] >>> 14;
	assign ysh = y_s[N] >>> 14;

	always_ff @(posedge clk) begin
		if (en) begin
			cos_val <= neg_s[N] ? -xsh[31:0] : xsh[31:0];
			sin_val <= neg_s[N] ? -ysh[31:0] : ysh[31:0];
		end
	end

endmodule

FILE: src/tire_bicycle_dynamics_top.sv
// channel  dir  handshake          payload, lsb first
// s_*      in   s_tvalid/s_tready  heading, long_speed, lat_speed, turn_rate, drive_cmd, steer_angle
// m_*      out  m_tvalid/m_tready  pos_x_rate, pos_y_rate, heading_rate, long_accel, lat_accel,
//                                  yaw_accel
// cfg_*    in   cfg_we             cfg_idx selects register 0..7, cfg_data up to 48 bits
//
// one transaction per cycle while the pipe is not held
// data passes three chains of 17 cordic stages in series (slip atan2, tire atan, tire sine),
// plus the angle modulo stages and one register after every multiply
// arst_n clears valid bits and the config registers; data registers are not reset
// the whole pipe holds only while the output register is full and not taken
module tire_bicycle_dynamics_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// heading, long_speed, lat_speed, turn_rate, drive_cmd, steer_angle
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// pos_x_rate, pos_y_rate, heading_rate, long_accel, lat_accel, yaw_accel
	output logic [191:0] m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [47:0]  cfg_data
);

	localparam int AT_LAT = tbd_pkg::AT_LAT;
	localparam int SC_LAT = tbd_pkg::SC_LAT;
	localparam int P1 = 2 + AT_LAT;
	localparam int P2 = P1 + 2 + AT_LAT;
	localparam int P3 = P2 + 1 + SC_LAT;
	localparam int F0 = P3 + 1;
	localparam int NSTG = F0 + 6;

	tbd_pkg::q_t motor_gain_q, speed_loss_q, drag_q, roll_q;
	logic [47:0] front_bcd_q, rear_bcd_q, axles_q, inv_mi_q;

	logic        pipe_en;
	logic [NSTG:1] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_gain_q <= '0;
			speed_loss_q <= '0;
			drag_q <= '0;
			roll_q <= '0;
			front_bcd_q <= '0;
			rear_bcd_q <= '0;
			axles_q <= '0;
			inv_mi_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				tbd_pkg::REG_MOTOR_GAIN: motor_gain_q <= cfg_data[31:0];
				tbd_pkg::REG_SPEED_LOSS: speed_loss_q <= cfg_data[31:0];
				tbd_pkg::REG_DRAG: drag_q <= cfg_data[31:0];
				tbd_pkg::REG_ROLL: roll_q <= cfg_data[31:0];
				tbd_pkg::REG_FRONT_BCD: front_bcd_q <= cfg_data;
				tbd_pkg::REG_REAR_BCD: rear_bcd_q <= cfg_data;
				tbd_pkg::REG_AXLES: axles_q <= cfg_data;
				tbd_pkg::REG_INV_MI: inv_mi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [32:0] lf33, lr33, invm33, invi33;
	assign lf33 = tbd_pkg::axle33(axles_q[23:0]);
	assign lr33 = tbd_pkg::axle33(axles_q[47:24]);
	assign invm33 = tbd_pkg::inv33(inv_mi_q[23:0]);
	assign invi33 = tbd_pkg::inv33(inv_mi_q[47:24]);

	assign pipe_en = !vld_s[NSTG] || m_tready;
	assign s_tready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (pipe_en) begin
			vld_s <= {vld_s[NSTG-1:1], s_tvalid};
		end
	end

	tbd_pkg::q_t heading_in, vx_in, vy_in, r_in, drive_in, steer_in;
	assign heading_in = s_tdata[31:0];
	assign vx_in = s_tdata[63:32];
	assign vy_in = s_tdata[95:64];
	assign r_in = s_tdata[127:96];
	assign drive_in = s_tdata[159:128];
	assign steer_in = s_tdata[191:160];

	// stage 1: first products
	tbd_pkg::q_t heading_s1, vx_s1, vy_s1, r_s1, drive_s1, steer_s1;
	tbd_pkg::q_t mlr_s1, mlf_s1, msl_s1, mdv_s1;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			heading_s1 <= heading_in;
			vx_s1 <= vx_in;
			vy_s1 <= vy_in;
			r_s1 <= r_in;
			drive_s1 <= drive_in;
			steer_s1 <= steer_in;
			mlr_s1 <= tbd_pkg::mulq(lr33, r_in);
			mlf_s1 <= tbd_pkg::mulq(lf33, r_in);
			msl_s1 <= tbd_pkg::mulq(tbd_pkg::ext33(speed_loss_q), vx_in);
			mdv_s1 <= tbd_pkg::mulq(tbd_pkg::ext33(drag_q), vx_in);
		end
	end

	// stage 2: slip numerators, drive gain, drag
	tbd_pkg::q_t heading_s2, steer_s2, ya_s2, yf_s2;
	tbd_pkg::side_t side_s2;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			heading_s2 <= heading_s1;
			steer_s2 <= steer_s1;
			ya_s2 <= tbd_pkg::sub_q(mlr_s1, vy_s1);
			yf_s2 <= tbd_pkg::nsum_q(vy_s1, mlf_s1);
			side_s2.vx <= vx_s1;
			side_s2.vy <= vy_s1;
			side_s2.r <= r_s1;
			side_s2.drive <= drive_s1;
			side_s2.fx1 <= tbd_pkg::sub_q(motor_gain_q, msl_s1);
			side_s2.fdrag <= tbd_pkg::mulq(tbd_pkg::ext33(mdv_s1), vx_s1);
		end
	end

	// slip angles
	tbd_pkg::q_t ar_raw, af_raw, steer_d;

	tbd_atan2 u_slip_r (.clk(clk), .en(pipe_en), .yv(ya_s2), .xv(side_s2.vx), .angle(ar_raw));
	tbd_atan2 u_slip_f (.clk(clk), .en(pipe_en), .yv(yf_s2), .xv(side_s2.vx), .angle(af_raw));

	tbd_delay #(.W(32), .DEPTH(AT_LAT)) u_steer_dly (
		.clk(clk), .en(pipe_en), .d(steer_s2), .q(steer_d)
	);

	tbd_pkg::q_t ar_s21, af_s21, pbr_s22, pbf_s22;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ar_s21 <= ar_raw;
			af_s21 <= tbd_pkg::add_q(steer_d, af_raw);
			pbr_s22 <= tbd_pkg::mulq(tbd_pkg::tire33(rear_bcd_q[15:0]), ar_s21);
			pbf_s22 <= tbd_pkg::mulq(tbd_pkg::tire33(front_bcd_q[15:0]), af_s21);
		end
	end

	// atan(B*alpha)
	tbd_pkg::q_t atr, atf;

	tbd_atan2 u_tire_at_r (.clk(clk), .en(pipe_en), .yv(pbr_s22), .xv(tbd_pkg::ONE_Q), .angle(atr));
	tbd_atan2 u_tire_at_f (.clk(clk), .en(pipe_en), .yv(pbf_s22), .xv(tbd_pkg::ONE_Q), .angle(atf));

	tbd_pkg::q_t ctr_s41, ctf_s41;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ctr_s41 <= tbd_pkg::mulq(tbd_pkg::tire33(rear_bcd_q[31:16]), atr);
			ctf_s41 <= tbd_pkg::mulq(tbd_pkg::tire33(front_bcd_q[31:16]), atf);
		end
	end

	tbd_pkg::q_t sr, sf;

	tbd_sincos u_tire_sin_r (.clk(clk), .en(pipe_en), .angle(ctr_s41), .sin_val(sr), .cos_val());
	tbd_sincos u_tire_sin_f (.clk(clk), .en(pipe_en), .angle(ctf_s41), .sin_val(sf), .cos_val());

	tbd_pkg::q_t fr_s63, ff_s63;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fr_s63 <= tbd_pkg::mulq(tbd_pkg::tire33(rear_bcd_q[47:32]), sr);
			ff_s63 <= tbd_pkg::mulq(tbd_pkg::tire33(front_bcd_q[47:32]), sf);
		end
	end

	// heading and steering trig, aligned with the tire forces
	tbd_pkg::trig_t trig_w, trig_d;

	tbd_sincos u_yaw_sc (
		.clk(clk), .en(pipe_en), .angle(heading_s2), .sin_val(trig_w.sy), .cos_val(trig_w.cy)
	);
	tbd_sincos u_steer_sc (
		.clk(clk), .en(pipe_en), .angle(steer_s2), .sin_val(trig_w.ss), .cos_val(trig_w.cs)
	);

	tbd_delay #(.W($bits(tbd_pkg::trig_t)), .DEPTH(F0 - 2 - SC_LAT)) u_trig_dly (
		.clk(clk), .en(pipe_en), .d(trig_w), .q(trig_d)
	);

	tbd_pkg::side_t side_d;

	tbd_delay #(.W($bits(tbd_pkg::side_t)), .DEPTH(F0 - 2)) u_side_dly (
		.clk(clk), .en(pipe_en), .d(side_s2), .q(side_d)
	);

	// output combination
	tbd_pkg::q_t ffss_s64, ffcs_s64, fflf_s64, frlr_s64, vyr_s64, vxr_s64, fxd_s64;
	tbd_pkg::q_t vxcy_s64, vysy_s64, vxsy_s64, vycy_s64, fdrag_s64, r_s64, cs_s64, fr_s64;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ffss_s64 <= tbd_pkg::mulq(tbd_pkg::ext33(ff_s63), trig_d.ss);
			ffcs_s64 <= tbd_pkg::mulq(tbd_pkg::ext33(ff_s63), trig_d.cs);
			fflf_s64 <= tbd_pkg::mulq(lf33, ff_s63);
			frlr_s64 <= tbd_pkg::mulq(lr33, fr_s63);
			vyr_s64 <= tbd_pkg::mulq(tbd_pkg::ext33(side_d.vy), side_d.r);
			vxr_s64 <= tbd_pkg::mulq(tbd_pkg::ext33(side_d.vx), side_d.r);
			fxd_s64 <= tbd_pkg::mulq(tbd_pkg::ext33(side_d.fx1), side_d.drive);
			vxcy_s64 <= tbd_pkg::mulq(tbd_pkg::ext33(side_d.vx), trig_d.cy);
			vysy_s64 <= tbd_pkg::mulq(tbd_pkg::ext33(side_d.vy), trig_d.sy);
			vxsy_s64 <= tbd_pkg::mulq(tbd_pkg::ext33(side_d.vx), trig_d.sy);
			vycy_s64 <= tbd_pkg::mulq(tbd_pkg::ext33(side_d.vy), trig_d.cy);
			fdrag_s64 <= side_d.fdrag;
			r_s64 <= side_d.r;
			cs_s64 <= trig_d.cs;
			fr_s64 <= fr_s63;
		end
	end

	tbd_pkg::q_t fxa_s65, lats_s65, yawa_s65, px_s65, py_s65, ffss_s65, frlr_s65;
	tbd_pkg::q_t vyr_s65, vxr_s65, r_s65;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fxa_s65 <= tbd_pkg::sub_q(fxd_s64, fdrag_s64);
			lats_s65 <= tbd_pkg::add_q(fr_s64, ffcs_s64);
			yawa_s65 <= tbd_pkg::mulq(tbd_pkg::ext33(fflf_s64), cs_s64);
			px_s65 <= tbd_pkg::sub_q(vxcy_s64, vysy_s64);
			py_s65 <= tbd_pkg::add_q(vxsy_s64, vycy_s64);
			ffss_s65 <= ffss_s64;
			frlr_s65 <= frlr_s64;
			vyr_s65 <= vyr_s64;
			vxr_s65 <= vxr_s64;
			r_s65 <= r_s64;
		end
	end

	tbd_pkg::q_t fxb_s66, latm_s66, yawb_s66, px_s66, py_s66, ffss_s66, vyr_s66, vxr_s66, r_s66;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fxb_s66 <= tbd_pkg::sub_q(fxa_s65, roll_q);
			latm_s66 <= tbd_pkg::mulq(invm33, lats_s65);
			yawb_s66 <= tbd_pkg::sub_q(yawa_s65, frlr_s65);
			px_s66 <= px_s65;
			py_s66 <= py_s65;
			ffss_s66 <= ffss_s65;
			vyr_s66 <= vyr_s65;
			vxr_s66 <= vxr_s65;
			r_s66 <= r_s65;
		end
	end

	tbd_pkg::q_t longs_s67, lat_s67, yaw_s67, px_s67, py_s67, vyr_s67, r_s67;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			longs_s67 <= tbd_pkg::sub_q(fxb_s66, ffss_s66);
			lat_s67 <= tbd_pkg::sub_q(latm_s66, vxr_s66);
			yaw_s67 <= tbd_pkg::mulq(invi33, yawb_s66);
			px_s67 <= px_s66;
			py_s67 <= py_s66;
			vyr_s67 <= vyr_s66;
			r_s67 <= r_s66;
		end
	end

	tbd_pkg::q_t longm_s68, lat_s68, yaw_s68, px_s68, py_s68, vyr_s68, r_s68;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			longm_s68 <= tbd_pkg::mulq(invm33, longs_s67);
			lat_s68 <= lat_s67;
			yaw_s68 <= yaw_s67;
			px_s68 <= px_s67;
			py_s68 <= py_s67;
			vyr_s68 <= vyr_s67;
			r_s68 <= r_s67;
		end
	end

	logic [191:0] tdata_s69;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			tdata_s69 <= {yaw_s68, lat_s68, tbd_pkg::add_q(longm_s68, vyr_s68), r_s68,
				py_s68, px_s68};
		end
	end

	assign m_tvalid = vld_s[NSTG];
	assign m_tdata = tdata_s69;

	assert property (@(posedge clk) disable iff (!arst_n) !m_tvalid |-> s_tready)
		else $error("input blocked while output register is empty");

	assert property (@(posedge clk) disable iff (!arst_n) !pipe_en |=> vld_s == $past(vld_s))
		else $error("valid bits moved during a stall");

	assert property (@(posedge clk) disable iff (!arst_n) $rose(m_tvalid) |-> $past(vld_s[NSTG-1]))
		else $error("output valid without a transaction in the last stage");

endmodule

FILE: tb/sv/tire_bicycle_dynamics_checker.sv
`timescale 1ns / 100ps

module tire_bicycle_dynamics_checker (
	input  logic         clk,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [191:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [191:0] m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_idx,
	input  logic [47:0]  cfg_data,
	output int           fail_count,
	output int           pending
);

	localparam longint ANGLE_STEP [17] = '{
		51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1
	};
	localparam longint TWO_PI = 411775;
	localparam longint PI = 205887;
	localparam longint HALF_PI = 102944;

	longint gain = 0, speed_loss = 0, drag = 0, roll = 0;
	longint front_bcd = 0, rear_bcd = 0, axles = 0, inv_mi = 0;
	int errors = 0;
	logic [191:0] deriv_q [$];

	string field_name [6] = '{"pos_x_rate", "pos_y_rate", "heading_rate",
		"long_accel", "lat_accel", "yaw_accel"};

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint fxmul(input longint a, input longint b);
		return clamp32((a * b) >>> 16);
	endfunction

	function automatic longint sx32(input logic [31:0] u);
		return longint'($signed(u));
	endfunction

	function automatic void sin_cos(input longint a, output longint s, output longint c);
		longint r, x, y, dx, dy;
		bit flip;
		r = a % TWO_PI;
		x = 652032874;
		y = 0;
		flip = 0;
		if (r < 0) r += TWO_PI;
		if (r > PI) r -= TWO_PI;
		if (r > HALF_PI) begin
			r -= PI;
			flip = 1;
		end else if (r < -HALF_PI) begin
			r += PI;
			flip = 1;
		end
		for (int i = 0; i < 17; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (r >= 0) begin
				x -= dx; y += dy; r -= ANGLE_STEP[i];
			end else begin
				x += dx; y -= dy; r += ANGLE_STEP[i];
			end
		end
		x = x >>> 14;
		y = y >>> 14;
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint angle_of(input longint yv, input longint xv);
		longint x, y, z, dx, dy;
		x = xv * 65536;
		y = yv * 65536;
		z = 0;
		if (xv == 0 && yv == 0) return 0;
		if (xv < 0) begin
			z = (yv >= 0) ? PI : -PI;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 17; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += ANGLE_STEP[i];
			end else begin
				x -= dx; y += dy; z -= ANGLE_STEP[i];
			end
		end
		return z;
	endfunction

	function automatic longint tire_force(input longint bcd, input longint slip);
		longint b, c, d, s, co, at;
		b = (bcd & 64'hffff) << 8;
		c = ((bcd >> 16) & 64'hffff) << 8;
		d = ((bcd >> 32) & 64'hffff) << 8;
		at = angle_of(fxmul(b, slip), 65536);
		sin_cos(fxmul(c, at), s, co);
		return fxmul(d, s);
	endfunction

	function automatic logic [191:0] predict_derivs(input logic [191:0] st);
		longint yaw, vx, vy, r, drv, steer, lf, lr, im, ii;
		longint sy, cy, ss, cs, fx, ar, af, fr, ff;
		longint d [6];
		logic [191:0] res;
		yaw = sx32(st[31:0]);
		vx = sx32(st[63:32]);
		vy = sx32(st[95:64]);
		r = sx32(st[127:96]);
		drv = sx32(st[159:128]);
		steer = sx32(st[191:160]);
		lf = axles & 64'hffffff;
		lr = (axles >> 24) & 64'hffffff;
		im = (inv_mi & 64'hffffff) << 4;
		ii = ((inv_mi >> 24) & 64'hffffff) << 4;

		fx = fxmul(clamp32(gain - fxmul(speed_loss, vx)), drv);
		fx = clamp32(fx - fxmul(fxmul(drag, vx), vx));
		fx = clamp32(fx - roll);
		ar = angle_of(clamp32(-vy + fxmul(lr, r)), vx);
		af = clamp32(steer + angle_of(clamp32(-vy - fxmul(lf, r)), vx));
		fr = tire_force(rear_bcd, ar);
		ff = tire_force(front_bcd, af);
		sin_cos(yaw, sy, cy);
		sin_cos(steer, ss, cs);

		d[0] = clamp32(fxmul(vx, cy) - fxmul(vy, sy));
		d[1] = clamp32(fxmul(vx, sy) + fxmul(vy, cy));
		d[2] = r;
		d[3] = clamp32(fxmul(im, clamp32(fx - fxmul(ff, ss))) + fxmul(vy, r));
		d[4] = clamp32(fxmul(im, clamp32(fr + fxmul(ff, cs))) - fxmul(vx, r));
		d[5] = fxmul(ii, clamp32(fxmul(fxmul(ff, lf), cs) - fxmul(fr, lr)));
		for (int k = 0; k < 6; k++) begin
			res[k*32 +: 32] = d[k][31:0];
		end
		return res;
	endfunction

	assign fail_count = errors;
	assign pending = deriv_q.size();

	always @(posedge clk) begin
		logic [191:0] want;
		if (cfg_we) begin
			case (cfg_idx)
				tbd_pkg::REG_MOTOR_GAIN: gain = sx32(cfg_data[31:0]);
				tbd_pkg::REG_SPEED_LOSS: speed_loss = sx32(cfg_data[31:0]);
				tbd_pkg::REG_DRAG: drag = sx32(cfg_data[31:0]);
				tbd_pkg::REG_ROLL: roll = sx32(cfg_data[31:0]);
				tbd_pkg::REG_FRONT_BCD: front_bcd = longint'(cfg_data);
				tbd_pkg::REG_REAR_BCD: rear_bcd = longint'(cfg_data);
				tbd_pkg::REG_AXLES: axles = longint'(cfg_data);
				tbd_pkg::REG_INV_MI: inv_mi = longint'(cfg_data);
				default: ;
			endcase
		end
		if (s_tvalid && s_tready) begin
			deriv_q.insert(deriv_q.size(), predict_derivs(s_tdata));
		end
		if (m_tvalid && m_tready) begin
			if (deriv_q.size() == 0) begin
				$display("%0t: unexpected output transaction %h", $time, m_tdata);
				errors++;
			end else begin
				want = deriv_q.pop_front();
				for (int k = 0; k < 6; k++) begin
					if (m_tdata[k*32 +: 32] !== want[k*32 +: 32]) begin
						$display("%0t: %s expected %h actual %h", $time, field_name[k],
							want[k*32 +: 32], m_tdata[k*32 +: 32]);
						errors++;
					end
				end
			end
		end
	end

endmodule

FILE: tb/sv/tire_bicycle_dynamics_top_tb.sv
`timescale 1ns / 100ps

module tire_bicycle_dynamics_top_tb;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [191:0] m_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_idx;
	logic [47:0]  cfg_data;
	int           fail_count;
	int           pending;
	logic         want_stall;
	int           burst_left;

	localparam logic [31:0] EDGE_VALS [12] = '{
		32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h1, 32'h10000,
		32'hffff0000, 32'd205887, 32'd102944, 32'd411775, 32'hfffcdbc1, 32'h00050000
	};

	tire_bicycle_dynamics_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	tire_bicycle_dynamics_checker chk (
		.clk(clk), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int mode_left, mode, hold;
		bit long_done;
		m_tready = 0;
		mode_left = 0;
		mode = 0;
		hold = 0;
		long_done = 0;
		forever begin
			@(negedge clk);
			if (want_stall && !long_done) begin
				long_done = 1;
				hold = 400;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			if (hold > 0) begin
				hold--;
				m_tready <= 0;
			end else if (mode == 0) begin
				m_tready <= 1;
			end else if (mode == 1) begin
				m_tready <= 1'($urandom_range(0, 1));
			end else begin
				m_tready <= ($urandom_range(0, 7) != 0);
			end
		end
	end

	function automatic logic [31:0] rand_field(input bit tame);
		if (tame) begin
			return $urandom_range(0, 20 * 65536) - 10 * 65536;
		end
		return $urandom;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic send_state(input logic [191:0] st);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			if ($urandom_range(0, 3) != 0) begin
				s_tvalid <= 0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1;
		s_tdata <= st;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_edges();
		logic [191:0] st;
		send_state('0);
		for (int k = 0; k < 20; k++) begin
			for (int f = 0; f < 6; f++) begin
				st[f*32 +: 32] = EDGE_VALS[(k + f * 5) % 12];
			end
			send_state(st);
		end
		s_tvalid <= 0;
	endtask

	task automatic send_random(input int n);
		logic [191:0] st;
		bit tame;
		for (int k = 0; k < n; k++) begin
			tame = ($urandom_range(0, 9) < 7);
			for (int f = 0; f < 6; f++) begin
				st[f*32 +: 32] = rand_field(tame);
			end
			send_state(st);
		end
		s_tvalid <= 0;
	endtask

	task automatic load_random_cfg();
		write_reg(tbd_pkg::REG_MOTOR_GAIN, 48'({$urandom, $urandom}));
		write_reg(tbd_pkg::REG_SPEED_LOSS, 48'({$urandom, $urandom}));
		write_reg(tbd_pkg::REG_DRAG, 48'({$urandom, $urandom}));
		write_reg(tbd_pkg::REG_ROLL, 48'({$urandom, $urandom}));
		write_reg(tbd_pkg::REG_FRONT_BCD, 48'({$urandom, $urandom}));
		write_reg(tbd_pkg::REG_REAR_BCD, 48'({$urandom, $urandom}));
		write_reg(tbd_pkg::REG_AXLES, 48'({$urandom, $urandom}));
		write_reg(tbd_pkg::REG_INV_MI, 48'({$urandom, $urandom}));
	endtask

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		cfg_we = 0;
		cfg_idx = '0;
		cfg_data = '0;
		want_stall = 0;
		burst_left = 0;
		repeat (11) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_edges();
		drain();

		// plausible vehicle
		write_reg(tbd_pkg::REG_MOTOR_GAIN, 48'h0000_0002_0000);
		write_reg(tbd_pkg::REG_SPEED_LOSS, 48'h0000_0000_199a);
		write_reg(tbd_pkg::REG_DRAG, 48'h0000_0000_0ccd);
		write_reg(tbd_pkg::REG_ROLL, 48'h0000_0000_4ccd);
		write_reg(tbd_pkg::REG_FRONT_BCD, 48'h0300_0180_0800);
		write_reg(tbd_pkg::REG_REAR_BCD, 48'h0340_0190_0900);
		write_reg(tbd_pkg::REG_AXLES, 48'h014ccd_013333);
		write_reg(tbd_pkg::REG_INV_MI, 48'h001000_000800);
		send_edges();
		want_stall <= 1;
		send_random(600);
		drain();

		// upper extremes, junk above the signed registers
		write_reg(tbd_pkg::REG_MOTOR_GAIN, 48'hffff_7fff_ffff);
		write_reg(tbd_pkg::REG_SPEED_LOSS, 48'h5a5a_7fff_ffff);
		write_reg(tbd_pkg::REG_DRAG, 48'hffff_7fff_ffff);
		write_reg(tbd_pkg::REG_ROLL, 48'ha5a5_7fff_ffff);
		write_reg(tbd_pkg::REG_FRONT_BCD, 48'hffff_ffff_ffff);
		write_reg(tbd_pkg::REG_REAR_BCD, 48'hffff_ffff_ffff);
		write_reg(tbd_pkg::REG_AXLES, 48'hffff_ffff_ffff);
		write_reg(tbd_pkg::REG_INV_MI, 48'hffff_ffff_ffff);
		send_edges();
		send_random(300);
		drain();

		// lower extremes
		write_reg(tbd_pkg::REG_MOTOR_GAIN, 48'h0000_8000_0000);
		write_reg(tbd_pkg::REG_SPEED_LOSS, 48'h0000_8000_0000);
		write_reg(tbd_pkg::REG_DRAG, 48'h0000_8000_0000);
		write_reg(tbd_pkg::REG_ROLL, 48'h0000_8000_0000);
		write_reg(tbd_pkg::REG_FRONT_BCD, 48'h0000_0000_0001);
		write_reg(tbd_pkg::REG_REAR_BCD, 48'h0001_0001_0000);
		write_reg(tbd_pkg::REG_AXLES, 48'h000000_000000);
		write_reg(tbd_pkg::REG_INV_MI, 48'h000001_000001);
		send_random(300);
		drain();

		for (int p = 0; p < 3; p++) begin
			load_random_cfg();
			send_random(200);
			drain();
		end

		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
src/tbd_pkg.sv
src/tbd_delay.sv
src/tbd_atan2.sv
src/tbd_sincos.sv
src/tire_bicycle_dynamics_top.sv
tb/sv/tire_bicycle_dynamics_checker.sv
tb/sv/tire_bicycle_dynamics_top_tb.sv
